// ----- rtl/iers_pkg.sv -----
// Shared types and constants for the ICMP echo reply checksummer.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package iers_pkg;

  // Packet shape limits
  localparam int unsigned IP_HDR_BYTES     = 20;
  localparam int unsigned MIN_PACKET_BYTES = 28;
  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam logic [7:0]  ECHO_REQUEST     = 8'h08;

  // Byte offsets within the packet
  localparam logic [16:0] IDX_IP_CSUM_HI   = 17'd10;
  localparam logic [16:0] IDX_IP_CSUM_LO   = 17'd11;
  localparam logic [16:0] IDX_ICMP_TYPE    = 17'd20;
  localparam logic [16:0] IDX_ICMP_CSUM_HI = 17'd22;
  localparam logic [16:0] IDX_ICMP_CSUM_LO = 17'd23;

  // Byte counter saturates here (oversize mark)
  localparam logic [16:0] COUNT_SAT = 17'h10000;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE = 1'b0;

  // One input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_ipv4;
    logic [5:0] header_len;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic        verdict;
    logic [16:0] packet_length;
    logic [15:0] ip_checksum;
    logic [15:0] icmp_checksum;
  } out_beat_t;

  // Settings from the register block
  typedef struct packed {
    logic enable;
  } cfg_t;

  // One's complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

// ----- rtl/icmp_echo_reply_checksummer.sv -----
// Top level of the ICMP echo reply checksummer.
// Depends on iers_pkg, iers_cfg and iers_accum.
//
//   channel | direction | beat type  | handshake
//   in_     | input     | in_beat_t  | in_valid / in_stall
//   out_    | output    | out_beat_t | out_valid / out_stall
//   cfg_    | input     | 32-bit reg | APB-style, pready tied high
//
// One byte per cycle sustained while no waiting result holds back a last byte.
// A byte first sits in the input register, then updates the packet sums; a last
// byte also writes the result register, which drives out_valid.
// Synchronous active-low reset clears the sums and the enable register.
// A waiting result stalls the input only when the next byte in line is also
// a last byte; other bytes keep flowing.
`timescale 1ns / 1ps

module icmp_echo_reply_checksummer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  iers_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output iers_pkg::out_beat_t              out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [iers_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [iers_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [iers_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import iers_pkg::*;

  cfg_t      cfg;
  in_beat_t  beat_r;
  logic      beat_valid_r, beat_valid_nxt;
  out_beat_t result;
  out_beat_t out_r;
  logic      out_valid_r, out_valid_nxt;
  logic      out_free;
  logic      beat_fire;
  logic      in_fire;

  iers_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Input register advances unless a last byte meets a full, stalled result register
  assign out_free  = ~out_valid_r | ~out_stall;
  assign beat_fire = beat_valid_r & (~beat_r.last_byte | out_free);
  assign in_stall  = beat_valid_r & ~beat_fire;
  assign in_fire   = in_valid & ~in_stall;

  assign beat_valid_nxt = in_fire | (beat_valid_r & ~beat_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else begin
      beat_valid_r <= beat_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      beat_r <= in_data;
    end
  end

  iers_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_fire (beat_fire),
    .beat      (beat_r),
    .cfg       (cfg),
    .result    (result)
  );

  // Result register
  assign out_valid_nxt = (beat_fire & beat_r.last_byte) | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_fire && beat_r.last_byte) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/iers_cfg.sv -----
// Register block for the ICMP echo reply checksummer (APB-style access).
// Depends on iers_pkg.
`timescale 1ns / 1ps

module iers_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [iers_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [iers_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [iers_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output iers_pkg::cfg_t                   cfg
);
  import iers_pkg::*;

  logic enable_r;
  logic enable_nxt;
  logic wr_en;

  // Write strobe on the access phase
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    enable_nxt = enable_r;
    if (wr_en && cfg_paddr == REG_ENABLE) begin
      enable_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  // Read back
  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr)
      REG_ENABLE: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, enable_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg.enable = enable_r;

endmodule

// ----- rtl/iers_accum.sv -----
// Per-packet accumulator: byte counter, both checksum sums and shape checks.
// Depends on iers_pkg. Produces the result for the beat being consumed.
`timescale 1ns / 1ps

module iers_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat_fire,
  input  iers_pkg::in_beat_t   beat,
  input  iers_pkg::cfg_t       cfg,
  output iers_pkg::out_beat_t  result
);
  import iers_pkg::*;

  logic [16:0] byte_count_r, byte_count_nxt;
  logic [15:0] ip_sum_r, ip_sum_nxt;
  logic [15:0] icmp_sum_r, icmp_sum_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        req_r, req_nxt;
  logic        shape_ok_r, shape_ok_nxt;

  logic [16:0] idx;
  logic        in_range;
  logic        in_hdr;
  logic        in_icmp;
  logic [7:0]  vbyte;
  logic [15:0] word;
  logic [16:0] count;
  logic [15:0] icmp_final;
  logic        verdict;

  assign idx      = byte_count_r;
  assign in_range = ~idx[16];
  assign in_hdr   = idx < 17'(IP_HDR_BYTES);
  assign in_icmp  = in_range & ~in_hdr;

  // Checksum bytes and the ICMP type byte count as zero
  always_comb begin
    vbyte = beat.data_byte;
    if (in_hdr) begin
      if (idx == IDX_IP_CSUM_HI || idx == IDX_IP_CSUM_LO) vbyte = 8'd0;
    end else begin
      if (idx == IDX_ICMP_TYPE || idx == IDX_ICMP_CSUM_HI || idx == IDX_ICMP_CSUM_LO) begin
        vbyte = 8'd0;
      end
    end
  end

  assign word  = {held_r, vbyte};
  assign count = in_range ? (idx + 17'd1) : COUNT_SAT;

  // Sum updates: even bytes are held, odd bytes complete a word
  always_comb begin
    held_nxt     = held_r;
    ip_sum_nxt   = ip_sum_r;
    icmp_sum_nxt = icmp_sum_r;
    if (in_range) begin
      if (!idx[0]) begin
        held_nxt = vbyte;
      end else if (in_hdr) begin
        ip_sum_nxt = oc_add(ip_sum_r, word);
      end else begin
        icmp_sum_nxt = oc_add(icmp_sum_r, word);
      end
    end
  end

  // Odd ICMP tail: pad the final high byte with a zero low byte
  assign icmp_final = (in_icmp && !idx[0]) ? oc_add(icmp_sum_r, {vbyte, 8'd0}) : icmp_sum_nxt;

  assign req_nxt      = (idx == IDX_ICMP_TYPE) ? (beat.data_byte == ECHO_REQUEST) : req_r;
  assign shape_ok_nxt = shape_ok_r & beat.is_ipv4 & (beat.header_len == 6'(IP_HDR_BYTES));

  assign verdict = cfg.enable & shape_ok_nxt & req_nxt &
                   (count >= 17'(MIN_PACKET_BYTES)) & (count <= 17'(MAX_PACKET_BYTES));

  always_comb begin
    result.verdict       = verdict;
    result.packet_length = count;
    result.ip_checksum   = verdict ? ~ip_sum_nxt : 16'd0;
    result.icmp_checksum = verdict ? ~icmp_final : 16'd0;
  end

  // State advances per consumed beat and clears after the last one
  assign byte_count_nxt = count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      ip_sum_r     <= '0;
      icmp_sum_r   <= '0;
      held_r       <= '0;
      req_r        <= 1'b0;
      shape_ok_r   <= 1'b1;
    end else if (beat_fire) begin
      if (beat.last_byte) begin
        byte_count_r <= '0;
        ip_sum_r     <= '0;
        icmp_sum_r   <= '0;
        held_r       <= '0;
        req_r        <= 1'b0;
        shape_ok_r   <= 1'b1;
      end else begin
        byte_count_r <= byte_count_nxt;
        ip_sum_r     <= ip_sum_nxt;
        icmp_sum_r   <= icmp_sum_nxt;
        held_r       <= held_nxt;
        req_r        <= req_nxt;
        shape_ok_r   <= shape_ok_nxt;
      end
    end
  end

endmodule

// ----- rtl/iers_checker.sv -----
// Port-level checks for the ICMP echo reply checksummer, bound to the top.
// Depends on iers_pkg and icmp_echo_reply_checksummer.
`timescale 1ns / 1ps

module iers_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input iers_pkg::out_beat_t out_data
);
  import iers_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Forwarded packets carry zero checksums
  a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.verdict |->
      out_data.ip_checksum == 16'd0 && out_data.icmp_checksum == 16'd0)
    else $error("forwarded packet with nonzero checksum");

  // A reply needs a length in the legal range
  a_reply_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict |->
      out_data.packet_length >= 17'(MIN_PACKET_BYTES) &&
      out_data.packet_length <= 17'(MAX_PACKET_BYTES))
    else $error("reply with illegal packet length");

  // Every result counts at least one byte and no more than saturation
  a_len_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.packet_length != 17'd0 && out_data.packet_length <= COUNT_SAT)
    else $error("packet length out of bounds");

endmodule

bind icmp_echo_reply_checksummer iers_checker u_iers_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- sim/icmp_echo_reply_checksummer_tb.sv -----
// Testbench for icmp_echo_reply_checksummer: streams IPv4 packets byte by byte
// and checks each verdict, length and reply checksum against its own predictor.
// Depends on rtl/iers_pkg.sv and rtl/icmp_echo_reply_checksummer.sv.
`timescale 1ns / 1ps

module icmp_echo_reply_checksummer_tb;
  import iers_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [7:0]  ECHO_REPLY     = 8'h00;

  // One queued input beat with its lead-in gap
  typedef struct {
    in_beat_t    beat;
    int unsigned gap;
    bit          drain;
  } pending_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  icmp_echo_reply_checksummer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  pending_beat_t beats_q[$];
  out_beat_t     reply_q[$];
  int unsigned   mismatches = 0;
  bit            in_fire = 1'b0;
  bit            out_fire = 1'b0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;

  // Predictor state: running sums of the packet in flight
  logic        enable_copy = 1'b0;
  logic [16:0] pkt_bytes = '0;
  logic [15:0] hdr_acc = '0;
  logic [15:0] msg_acc = '0;
  logic [7:0]  hi_byte = '0;
  logic        type_echo = 1'b0;
  logic        shape_good = 1'b1;

  // 16-bit one's complement add, end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] wide;
    wide = {1'b0, acc} + {1'b0, word};
    return wide[15:0] + 16'(wide[16]);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Fold one accepted byte into the sums; a last byte yields the expected reply
  task automatic sum_packet_byte(input in_beat_t b);
    logic [16:0] idx;
    logic [16:0] cnt;
    logic [7:0]  v;
    logic        in_msg;
    logic        ok;
    out_beat_t   r;
    idx = pkt_bytes;
    in_msg = (idx >= IP_HDR_BYTES) && (idx < COUNT_SAT);
    if (idx < COUNT_SAT) begin
      if (idx < IP_HDR_BYTES)
        v = (idx == IDX_IP_CSUM_HI || idx == IDX_IP_CSUM_LO) ? 8'h00 : b.data_byte;
      else
        v = (idx == IDX_ICMP_TYPE || idx == IDX_ICMP_CSUM_HI || idx == IDX_ICMP_CSUM_LO) ?
            8'h00 : b.data_byte;
      if (!idx[0]) hi_byte = v;
      else if (idx < IP_HDR_BYTES) hdr_acc = ones_add(hdr_acc, {hi_byte, v});
      else msg_acc = ones_add(msg_acc, {hi_byte, v});
    end
    if (idx == IDX_ICMP_TYPE) type_echo = (b.data_byte == ECHO_REQUEST);
    if (b.is_ipv4 !== 1'b1 || b.header_len != IP_HDR_BYTES) shape_good = 1'b0;
    cnt = (idx < COUNT_SAT) ? idx + 17'd1 : COUNT_SAT;
    if (!b.last_byte) begin
      pkt_bytes = cnt;
    end else begin
      // odd ICMP tail: pad with a zero low byte
      if (in_msg && !idx[0]) msg_acc = ones_add(msg_acc, {hi_byte, 8'h00});
      ok = enable_copy && shape_good && type_echo &&
           cnt >= MIN_PACKET_BYTES && cnt <= MAX_PACKET_BYTES;
      r.verdict       = ok;
      r.packet_length = cnt;
      r.ip_checksum   = ok ? ~hdr_acc : 16'h0000;
      r.icmp_checksum = ok ? ~msg_acc : 16'h0000;
      reply_q.push_back(r);
      pkt_bytes  = '0;
      hdr_acc    = '0;
      msg_acc    = '0;
      hi_byte    = '0;
      type_echo  = 1'b0;
      shape_good = 1'b1;
    end
  endtask

  task automatic compare_reply(input out_beat_t got);
    out_beat_t want;
    if (reply_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result verdict=%0d len=%0d ip=%h icmp=%h",
                              got.verdict, got.packet_length, got.ip_checksum,
                              got.icmp_checksum));
      return;
    end
    want = reply_q.pop_front();
    if (got.verdict !== want.verdict || got.packet_length !== want.packet_length ||
        got.ip_checksum !== want.ip_checksum || got.icmp_checksum !== want.icmp_checksum)
      flag_mismatch($sformatf({"expected verdict=%0d len=%0d ip=%h icmp=%h, ",
                               "got verdict=%0d len=%0d ip=%h icmp=%h"},
                              want.verdict, want.packet_length, want.ip_checksum,
                              want.icmp_checksum, got.verdict, got.packet_length,
                              got.ip_checksum, got.icmp_checksum));
  endtask

  // Monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    in_fire  <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) sum_packet_byte(in_data);
    if (rst_n && out_valid && !out_stall) compare_reply(out_data);
  end

  // Watchdog: too long with no beat moving on either side
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Input driver: one beat at a time from beats_q, each after its own gap
  int unsigned gap_left = 0;
  bit          gap_armed = 1'b0;
  always @(negedge clk) begin
    logic          present;
    pending_beat_t nb;
    present = 1'b0;
    if (in_valid && !in_fire) begin
      present = 1'b1;  // stalled beat holds
    end else if (rst_n && beats_q.size() > 0) begin
      if (!gap_armed) begin
        gap_left  = beats_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (!(beats_q[0].drain && reply_q.size() != 0)) begin
        nb = beats_q.pop_front();
        in_data  <= nb.beat;
        gap_armed = 1'b0;
        present   = 1'b1;
      end
    end
    in_valid <= present;
  end

  // Result side: random stall after each accepted result, with calm stretches
  int unsigned hold_left = 3;
  always @(negedge clk) begin
    if (out_fire) begin
      hold_left = rx_calm ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= REG_ENABLE;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic verify_enable_readback();
    logic [31:0] rd;
    apb_xfer(1'b0, $urandom, rd);
    if (rd !== 32'(enable_copy))
      flag_mismatch($sformatf("enable readback expected %h got %h", 32'(enable_copy), rd));
  endtask

  // Write enable with junk in the unused bits, then read it back
  task automatic program_enable(input logic val);
    logic [31:0] wd;
    logic [31:0] rd;
    wd    = $urandom;
    wd[0] = val;
    apb_xfer(1'b1, wd, rd);
    enable_copy = val;
    verify_enable_readback();
  endtask

  // Block is idle: nothing queued, nothing in flight, pipeline drained
  task automatic settle();
    while (beats_q.size() != 0 || in_valid || reply_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Queue one packet; the shape goes wrong at byte bad_at only (none if negative)
  task automatic queue_packet(input int len, input logic [7:0] icmp_type, input int fill,
                              input int bad_at, input logic bad_v4, input logic [5:0] bad_hl,
                              input bit big);
    pending_beat_t pb;
    for (int i = 0; i < len; i++) begin
      if (i == IDX_ICMP_TYPE) pb.beat.data_byte = icmp_type;
      else pb.beat.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
      pb.beat.last_byte  = (i == len - 1);
      pb.beat.is_ipv4    = (i == bad_at) ? bad_v4 : 1'b1;
      pb.beat.header_len = (i == bad_at) ? bad_hl : 6'(IP_HDR_BYTES);
      if (big) pb.gap = ($urandom_range(0, 4095) == 0) ? $urandom_range(1, 10) : 0;
      else pb.gap = tx_calm ? 0 : $urandom_range(0, 10);
      pb.drain = !big && i == 0 && $urandom_range(0, 5) == 0;
      beats_q.push_back(pb);
    end
    if ($urandom_range(0, 4) == 0) tx_calm = !tx_calm;
  endtask

  // Mostly well-formed echo requests, the rest broken or noise
  task automatic queue_random_traffic(input int unsigned byte_goal, input int unsigned pkt_goal);
    int unsigned bytes;
    int unsigned pkts;
    int          kind;
    int          len;
    int          bad_at;
    logic        bad_v4;
    logic [5:0]  bad_hl;
    logic [7:0]  ty;
    bytes = 0;
    pkts  = 0;
    while (bytes < byte_goal || pkts < pkt_goal) begin
      kind   = $urandom_range(0, 9);
      bad_at = -1;
      bad_v4 = 1'b1;
      bad_hl = 6'(IP_HDR_BYTES);
      ty     = ECHO_REQUEST;
      if (kind < 7) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 200) : $urandom_range(28, 64);
      end else if (kind == 7) begin
        len    = $urandom_range(28, 64);
        bad_at = $urandom_range(0, len - 1);
        bad_v4 = 1'($urandom_range(0, 1));
        bad_hl = 6'($urandom_range(0, 60));
        if (bad_v4 && bad_hl == IP_HDR_BYTES) bad_v4 = 1'b0;
      end else if (kind == 8) begin
        len = $urandom_range(1, 27);
      end else begin
        len = $urandom_range(1, 64);
        ty  = 8'($urandom);
        if ($urandom_range(0, 1)) begin
          bad_at = $urandom_range(0, len - 1);
          bad_v4 = 1'($urandom_range(0, 1));
          bad_hl = 6'($urandom_range(0, 60));
        end
      end
      queue_packet(len, ty, -1, bad_at, bad_v4, bad_hl, 1'b0);
      bytes += len;
      pkts++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    verify_enable_readback();

    // Disabled: a good echo request is only forwarded
    queue_packet(28, ECHO_REQUEST, -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    settle();
    program_enable(1'b1);

    // Directed packets: length edges, fill extremes, types, shape breaks
    queue_packet(28, ECHO_REQUEST, -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(29, ECHO_REQUEST, -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(27, ECHO_REQUEST, -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(21, ECHO_REQUEST, -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(20, ECHO_REQUEST, -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(1, ECHO_REQUEST, -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(40, ECHO_REQUEST, 255, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(28, ECHO_REQUEST, 0, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(30, ECHO_REPLY, -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(30, 8'($urandom_range(9, 255)), -1, -1, 1'b1, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(36, ECHO_REQUEST, -1, 25, 1'b0, 6'(IP_HDR_BYTES), 1'b0);
    queue_packet(28, ECHO_REQUEST, -1, 0, 1'b1, 6'd60, 1'b0);
    queue_packet(33, ECHO_REQUEST, -1, 32, 1'b1, 6'd0, 1'b0);
    queue_packet(30, ECHO_REQUEST, -1, 3, 1'b1, 6'd21, 1'b0);
    settle();

    // Random traffic under both enable settings
    queue_random_traffic(400, 8);
    settle();
    program_enable(1'b0);
    queue_random_traffic(250, 5);
    settle();
    program_enable(1'b1);
    queue_random_traffic(400, 8);
    settle();

    if (mismatches == 0 && reply_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
